[design/priority_aging_process_scheduler_defines.svh]
// assertion macros used by the scheduler checker
// clk_i and rst_ni must be visible where a macro is used
`ifndef PRIORITY_AGING_PROCESS_SCHEDULER_DEFINES_SVH
`define PRIORITY_AGING_PROCESS_SCHEDULER_DEFINES_SVH

// consequent checked in the same cycle
`define PAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define PAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pas_pkg.sv]
`default_nettype none

package pas_pkg;

  localparam int SLOTS_DEF         = 8;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int AGE_BITS_DEF      = 16;

  localparam int OP_W       = 3;
  localparam int PID_W      = 4;
  localparam int PRIO_IN_W  = 8;
  localparam int CFG_W      = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] CHILD_PRIO_RST = 8'd6;
  localparam int               SLOT0_PRIO     = 5;

  typedef enum logic [1:0] {
    ST_CREATED    = 2'd0,
    ST_READY      = 2'd1,
    ST_EXECUTING  = 2'd2,
    ST_TERMINATED = 2'd3
  } status_e;

  typedef enum logic [OP_W-1:0] {
    OP_SCHED = 3'd0,
    OP_FORK  = 3'd1,
    OP_EXIT  = 3'd2,
    OP_EXEC  = 3'd3,
    OP_KILL  = 3'd4,
    OP_NICE  = 3'd5
  } op_e;

endpackage

`default_nettype wire

[design/priority_aging_process_scheduler.sv]
// one item in flight at a time; result registered, held until taken
// schedule, exit and fork: the scan reads one table entry per cycle, then a finish step writes
//   the pick, and a second finish step returns the old slot to ready after a dispatch
// exec, kill and nice: one table read-modify-write; other items go straight to the result
// a new transaction is taken only once the previous result is registered, later while one is held
// reset: slot 0 created priority 5 and running, others terminated, ages zero, child prio 6
`default_nettype none

module priority_aging_process_scheduler #(
  parameter int SLOTS         = pas_pkg::SLOTS_DEF,
  parameter int PRIORITY_BITS = pas_pkg::PRIORITY_BITS_DEF,
  parameter int AGE_BITS      = pas_pkg::AGE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] target_pid, [11:4] new_priority, [15:12] zero
  input  wire logic [pas_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [2:0] operation
  input  wire logic [pas_pkg::OP_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [3:0] running_pid, [7:4] previous_pid, [8] switched, [12:9] fork_pid,
  // [13] error, [15:14] zero
  output logic [pas_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [pas_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int SLOT_W1 = SLOT_W + 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SC_W    = ((PRIORITY_BITS > AGE_BITS) ? PRIORITY_BITS : AGE_BITS) + 1;
  localparam int ENT_W   = 2 + PRIORITY_BITS + AGE_BITS;
  localparam int PID_W   = pas_pkg::PID_W;
  localparam int OUT_PAD = pas_pkg::OUT_DATA_W - (3 * PID_W + 2);

  typedef struct packed {
    pas_pkg::status_e          status;
    logic [PRIORITY_BITS-1:0]  prio;
    logic [AGE_BITS-1:0]       age;
  } ent_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_FIN1 = 7'b0000100,
    S_FIN2 = 7'b0001000,
    S_RD   = 7'b0010000,
    S_MOD  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  function automatic logic [PID_W-1:0] to_pid(logic [SLOT_W-1:0] slot);
    logic [SLOT_W:0] sum;
    sum = {1'b0, slot} + SLOT_W1'(1);
    return PID_W'(sum);
  endfunction

  state_e                         state_q, state_d;
  logic [pas_pkg::OP_W-1:0]       op_q, op_d;
  logic [SLOT_W-1:0]              tslot_q, tslot_d;
  logic [PRIORITY_BITS-1:0]       newp_q, newp_d;
  logic [SLOT_W-1:0]              running_q, running_d;
  logic [SLOT_W-1:0]              prev_q, prev_d;
  logic [CNT_W-1:0]               issue_q, issue_d;
  logic                           proc_vld_q, proc_vld_d;
  logic [SLOT_W-1:0]              proc_idx_q, proc_idx_d;
  logic [SC_W-1:0]                best_q, best_d;
  logic                           found_q, found_d;
  logic [SLOT_W-1:0]              pick_q, pick_d;
  pas_pkg::status_e               pick_stat_q, pick_stat_d;
  logic [PRIORITY_BITS-1:0]       pick_prio_q, pick_prio_d;
  ent_t                           prev_ent_q, prev_ent_d;
  logic                           child_found_q, child_found_d;
  logic [SLOT_W-1:0]              child_q, child_d;
  logic                           res_sw_q, res_sw_d;
  logic [PID_W-1:0]               res_fork_q, res_fork_d;
  logic                           res_err_q, res_err_d;
  logic                           m_tvalid_q, m_tvalid_d;
  logic [pas_pkg::OUT_DATA_W-1:0] m_tdata_q, m_tdata_d;
  logic [pas_pkg::CFG_W-1:0]      child_prio_q;

  logic [pas_pkg::OP_W-1:0]       in_op;
  logic [PID_W-1:0]               in_tpid;
  logic [pas_pkg::PRIO_IN_W-1:0]  in_newp;
  logic                           in_bad_pid;

  logic                           rd_en;
  logic [SLOT_W-1:0]              rd_addr;
  logic                           wr_en;
  logic [SLOT_W-1:0]              wr_addr;
  ent_t                           wr_ent;
  logic [ENT_W-1:0]               rd_data;
  ent_t                           ent;

  pas_pkg::status_e               cur_stat;
  logic [SC_W-1:0]                score;
  logic [AGE_BITS-1:0]            new_age;
  pas_pkg::status_e               fin_stat;
  logic [PRIORITY_BITS-1:0]       fin_prio;
  logic [SLOT_W-1:0]              fin_slot;

  assign in_op      = s_axis_tuser;
  assign in_tpid    = s_axis_tdata[PID_W-1:0];
  assign in_newp    = s_axis_tdata[PID_W +: pas_pkg::PRIO_IN_W];
  assign in_bad_pid = (in_tpid == '0) || (int'(in_tpid) > SLOTS);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign cfg_ready_o   = 1'b1;

  assign ent = ent_t'(rd_data);

  // scan arithmetic on the entry returned by the table this cycle
  always_comb begin
    if (op_q == pas_pkg::OP_EXIT && proc_idx_q == prev_q) begin
      cur_stat = pas_pkg::ST_TERMINATED;
    end else begin
      cur_stat = ent.status;
    end
    score = SC_W'(ent.prio) + SC_W'(ent.age);
    if (cur_stat == pas_pkg::ST_READY && !(&ent.age)) begin
      new_age = ent.age + AGE_BITS'(1);
    end else begin
      new_age = ent.age;
    end
    // no candidate keeps the running slot
    fin_stat = found_q ? pick_stat_q : prev_ent_q.status;
    fin_prio = found_q ? pick_prio_q : prev_ent_q.prio;
    fin_slot = found_q ? pick_q : prev_q;
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    tslot_d       = tslot_q;
    newp_d        = newp_q;
    running_d     = running_q;
    prev_d        = prev_q;
    issue_d       = issue_q;
    proc_vld_d    = 1'b0;
    proc_idx_d    = proc_idx_q;
    best_d        = best_q;
    found_d       = found_q;
    pick_d        = pick_q;
    pick_stat_d   = pick_stat_q;
    pick_prio_d   = pick_prio_q;
    prev_ent_d    = prev_ent_q;
    child_found_d = child_found_q;
    child_d       = child_q;
    res_sw_d      = res_sw_q;
    res_fork_d    = res_fork_q;
    res_err_d     = res_err_q;
    m_tvalid_d    = m_tvalid_q;
    m_tdata_d     = m_tdata_q;
    rd_en         = 1'b0;
    rd_addr       = tslot_q;
    wr_en         = 1'b0;
    wr_addr       = proc_idx_q;
    wr_ent        = ent;

    if (m_tvalid_q && m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d          = in_op;
          tslot_d       = SLOT_W'(in_tpid - PID_W'(1));
          newp_d        = PRIORITY_BITS'(in_newp);
          prev_d        = running_q;
          issue_d       = '0;
          best_d        = '0;
          found_d       = 1'b0;
          child_found_d = 1'b0;
          res_sw_d      = 1'b0;
          res_fork_d    = '0;
          res_err_d     = 1'b0;
          case (in_op) inside
            pas_pkg::OP_SCHED, pas_pkg::OP_FORK, pas_pkg::OP_EXIT: begin
              state_d = S_SCAN;
            end
            pas_pkg::OP_EXEC: begin
              tslot_d = running_q;
              state_d = S_RD;
            end
            pas_pkg::OP_KILL, pas_pkg::OP_NICE: begin
              if (in_bad_pid) begin
                res_err_d = 1'b1;
                state_d   = S_DONE;
              end else begin
                state_d = S_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read slot issue_q while slot proc_idx_q is updated and, except on a fork, written back
        if (issue_q != CNT_W'(SLOTS)) begin
          rd_en      = 1'b1;
          rd_addr    = issue_q[SLOT_W-1:0];
          issue_d    = issue_q + CNT_W'(1);
          proc_vld_d = 1'b1;
          proc_idx_d = issue_q[SLOT_W-1:0];
        end
        if (proc_vld_q) begin
          if (op_q == pas_pkg::OP_FORK) begin
            if (cur_stat == pas_pkg::ST_TERMINATED && !child_found_q) begin
              child_found_d = 1'b1;
              child_d       = proc_idx_q;
            end
          end else begin
            if (score > best_q && cur_stat != pas_pkg::ST_TERMINATED &&
                proc_idx_q != prev_q) begin
              best_d      = score;
              found_d     = 1'b1;
              pick_d      = proc_idx_q;
              pick_stat_d = cur_stat;
              pick_prio_d = ent.prio;
            end
            wr_en         = 1'b1;
            wr_addr       = proc_idx_q;
            wr_ent.status = cur_stat;
            wr_ent.prio   = ent.prio;
            wr_ent.age    = new_age;
            if (proc_idx_q == prev_q) begin
              prev_ent_d = wr_ent;
            end
          end
          if (proc_idx_q == SLOT_W'(SLOTS - 1)) begin
            state_d = S_FIN1;
          end
        end
      end

      S_FIN1: begin
        state_d = S_DONE;
        if (op_q == pas_pkg::OP_FORK) begin
          // slot 0 terminated, or none terminated, means the fork fails
          if (child_found_q && child_q != '0) begin
            wr_en         = 1'b1;
            wr_addr       = child_q;
            wr_ent.status = pas_pkg::ST_READY;
            wr_ent.prio   = PRIORITY_BITS'(child_prio_q);
            wr_ent.age    = '0;
            res_fork_d    = to_pid(child_q);
          end else begin
            res_err_d = 1'b1;
          end
        end else begin
          wr_en       = 1'b1;
          wr_addr     = fin_slot;
          wr_ent.prio = fin_prio;
          wr_ent.age  = '0;
          if (fin_stat == pas_pkg::ST_TERMINATED) begin
            wr_ent.status = pas_pkg::ST_TERMINATED;
          end else begin
            wr_ent.status = pas_pkg::ST_EXECUTING;
            running_d     = fin_slot;
            res_sw_d      = 1'b1;
            if (fin_slot != prev_q && prev_ent_q.status != pas_pkg::ST_TERMINATED) begin
              state_d = S_FIN2;
            end
          end
        end
      end

      S_FIN2: begin
        wr_en         = 1'b1;
        wr_addr       = prev_q;
        wr_ent.status = pas_pkg::ST_READY;
        wr_ent.prio   = prev_ent_q.prio;
        wr_ent.age    = prev_ent_q.age;
        state_d       = S_DONE;
      end

      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = tslot_q;
        state_d = S_MOD;
      end

      S_MOD: begin
        wr_addr = tslot_q;
        state_d = S_DONE;
        case (op_q)
          pas_pkg::OP_EXEC: begin
            wr_en = 1'b1;
            if (ent.status != pas_pkg::ST_TERMINATED) begin
              wr_ent.status = pas_pkg::ST_EXECUTING;
            end
          end
          pas_pkg::OP_KILL: begin
            wr_en         = 1'b1;
            wr_ent.status = pas_pkg::ST_TERMINATED;
          end
          pas_pkg::OP_NICE: begin
            wr_en       = 1'b1;
            wr_ent.prio = newp_q;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
      end

      S_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {{OUT_PAD{1'b0}}, res_err_q, res_fork_q, res_sw_q,
                        to_pid(prev_q), to_pid(running_q)};
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      running_q    <= '0;
      issue_q      <= '0;
      proc_vld_q   <= 1'b0;
      m_tvalid_q   <= 1'b0;
      child_prio_q <= pas_pkg::CHILD_PRIO_RST;
    end else begin
      state_q    <= state_d;
      running_q  <= running_d;
      issue_q    <= issue_d;
      proc_vld_q <= proc_vld_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_valid_i) begin
        child_prio_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    tslot_q       <= tslot_d;
    newp_q        <= newp_d;
    prev_q        <= prev_d;
    proc_idx_q    <= proc_idx_d;
    best_q        <= best_d;
    found_q       <= found_d;
    pick_q        <= pick_d;
    pick_stat_q   <= pick_stat_d;
    pick_prio_q   <= pick_prio_d;
    prev_ent_q    <= prev_ent_d;
    child_found_q <= child_found_d;
    child_q       <= child_d;
    res_sw_q      <= res_sw_d;
    res_fork_q    <= res_fork_d;
    res_err_q     <= res_err_d;
    m_tdata_q     <= m_tdata_d;
  end

  pas_slot_table #(
    .SLOTS         (SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .AGE_BITS      (AGE_BITS)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_ent),
    .rd_data_o (rd_data)
  );

endmodule

`default_nettype wire

[design/pas_slot_table.sv]
`default_nettype none

module pas_slot_table #(
  parameter int SLOTS         = pas_pkg::SLOTS_DEF,
  parameter int PRIORITY_BITS = pas_pkg::PRIORITY_BITS_DEF,
  parameter int AGE_BITS      = pas_pkg::AGE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             rd_en_i,
  input  wire logic [$clog2(SLOTS)-1:0]         rd_addr_i,
  input  wire logic                             wr_en_i,
  input  wire logic [$clog2(SLOTS)-1:0]         wr_addr_i,
  input  wire logic [2+PRIORITY_BITS+AGE_BITS-1:0] wr_data_i,
  output logic [2+PRIORITY_BITS+AGE_BITS-1:0]   rd_data_o
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ENT_W  = 2 + PRIORITY_BITS + AGE_BITS;

  logic [ENT_W-1:0]  mem_q [SLOTS];
  logic [SLOTS-1:0]  vld_q;
  logic [ENT_W-1:0]  rd_data_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_addr_q;
  logic [ENT_W-1:0]  rst_ent;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // per-entry written marks stand in for a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // slot 0 starts created with its own priority, the others terminated
  always_comb begin
    if (rd_addr_q == '0) begin
      rst_ent = {pas_pkg::ST_CREATED, PRIORITY_BITS'(pas_pkg::SLOT0_PRIO),
                 {AGE_BITS{1'b0}}};
    end else begin
      rst_ent = {pas_pkg::ST_TERMINATED, {PRIORITY_BITS{1'b0}}, {AGE_BITS{1'b0}}};
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : rst_ent;

endmodule

`default_nettype wire

[design/pas_checker.sv]
`default_nettype none
`include "priority_aging_process_scheduler_defines.svh"

module pas_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // a stalled result transaction keeps its payload
  `PAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // only one item is worked on at a time
  `PAS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // a dispatch never reports a child or an error
  `PAS_ASSERT_SAME(a_switch_excl, m_axis_tvalid && m_axis_tdata[8], (m_axis_tdata[12:9] == 4'd0) && !m_axis_tdata[13], "switch with fork pid or error")

  // a flagged error carries no child pid
  `PAS_ASSERT_SAME(a_err_no_child, m_axis_tvalid && m_axis_tdata[13], m_axis_tdata[12:9] == 4'd0, "error with fork pid")

endmodule

bind priority_aging_process_scheduler pas_checker u_pas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[sim/tb_priority_aging_process_scheduler.sv]
`timescale 1ns / 1ps

module tb_priority_aging_process_scheduler;
  import pas_pkg::*;

  localparam int NUM_SLOTS     = SLOTS_DEF;
  localparam int CLK_PERIOD    = 10;
  localparam int STALL_HOLD    = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = NUM_SLOTS + 8;

  // operation codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  wire                   cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  typedef struct {
    logic [PID_W-1:0] running_pid;
    logic [PID_W-1:0] previous_pid;
    logic             switched;
    logic [PID_W-1:0] fork_pid;
    logic             error;
  } sched_outcome_t;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [PID_W-1:0]     tpid;
    logic [PRIO_IN_W-1:0] newp;
  } sched_item_t;

  class sched_scoreboard;
    status_e                      slot_state [NUM_SLOTS];
    logic [PRIORITY_BITS_DEF-1:0] slot_prio  [NUM_SLOTS];
    logic [AGE_BITS_DEF-1:0]      slot_age   [NUM_SLOTS];
    int unsigned                  cur_slot;
    logic [CFG_W-1:0]             child_prio;
    sched_outcome_t               outcome_q[$];
    int unsigned                  mismatches;

    function new();
      int unsigned k;
      for (k = 0; k < NUM_SLOTS; k++) begin
        slot_state[k] = ST_TERMINATED;
        slot_prio[k]  = '0;
        slot_age[k]   = '0;
      end
      slot_state[0] = ST_CREATED;
      slot_prio[0]  = PRIORITY_BITS_DEF'(SLOT0_PRIO);
      cur_slot      = 0;
      child_prio    = CHILD_PRIO_RST;
      mismatches    = 0;
    endfunction

    // scan in slot order, ready slots age as the scan passes them
    function bit dispatch();
      int unsigned best, pick, prev, k, score;
      best = 0;
      pick = cur_slot;
      prev = cur_slot;
      for (k = 0; k < NUM_SLOTS; k++) begin
        score = slot_prio[k] + slot_age[k];
        if (score > best && slot_state[k] != ST_TERMINATED && k != cur_slot) begin
          best = score;
          pick = k;
        end
        if (slot_state[k] == ST_READY && slot_age[k] != {AGE_BITS_DEF{1'b1}})
          slot_age[k] = slot_age[k] + 1'b1;
      end
      slot_age[pick] = '0;
      if (slot_state[pick] == ST_TERMINATED) return 1'b0;
      cur_slot = pick;
      if (slot_state[prev] != ST_TERMINATED) slot_state[prev] = ST_READY;
      slot_state[pick] = ST_EXECUTING;
      return 1'b1;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [PID_W-1:0] tpid,
                             logic [PRIO_IN_W-1:0] newp);
      sched_outcome_t o;
      int unsigned    prev, child, k;
      prev       = cur_slot;
      o.switched = 1'b0;
      o.fork_pid = '0;
      o.error    = 1'b0;
      case (op)
        OP_SCHED: o.switched = dispatch();
        OP_FORK: begin
          child = NUM_SLOTS;
          for (k = 0; k < NUM_SLOTS; k++)
            if (child == NUM_SLOTS && slot_state[k] == ST_TERMINATED) child = k;
          // slot 0 is never handed out again once it has gone
          if (child == 0 || child >= NUM_SLOTS) begin
            o.error = 1'b1;
          end else begin
            slot_prio[child]  = PRIORITY_BITS_DEF'(child_prio);
            slot_age[child]   = '0;
            slot_state[child] = ST_READY;
            o.fork_pid        = PID_W'(child + 1);
          end
        end
        OP_EXIT: begin
          slot_state[cur_slot] = ST_TERMINATED;
          o.switched = dispatch();
        end
        OP_EXEC: begin
          if (slot_state[cur_slot] != ST_TERMINATED) slot_state[cur_slot] = ST_EXECUTING;
        end
        OP_KILL, OP_NICE: begin
          if (tpid < 1 || tpid > NUM_SLOTS) o.error = 1'b1;
          else if (op == OP_KILL) slot_state[tpid - 1] = ST_TERMINATED;
          else slot_prio[tpid - 1] = PRIORITY_BITS_DEF'(newp);
        end
        default: ;
      endcase
      o.running_pid  = PID_W'(cur_slot + 1);
      o.previous_pid = PID_W'(prev + 1);
      outcome_q.push_back(o);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      sched_outcome_t exp;
      if (outcome_q.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", d));
        return;
      end
      exp = outcome_q.pop_front();
      if (d[3:0] !== exp.running_pid)
        report($sformatf("running_pid %0d, want %0d", d[3:0], exp.running_pid));
      if (d[7:4] !== exp.previous_pid)
        report($sformatf("previous_pid %0d, want %0d", d[7:4], exp.previous_pid));
      if (d[8] !== exp.switched)
        report($sformatf("switched %b, want %b", d[8], exp.switched));
      if (d[12:9] !== exp.fork_pid)
        report($sformatf("fork_pid %0d, want %0d", d[12:9], exp.fork_pid));
      if (d[13] !== exp.error)
        report($sformatf("error %b, want %b", d[13], exp.error));
    endtask
  endclass

  sched_scoreboard sb;
  int unsigned     idle_cycles = 0;
  int unsigned     hold_seq    = 0;
  int unsigned     hold_seen   = 0;
  int unsigned     hold_left   = 0;
  int unsigned     rx_mode     = 0;
  int unsigned     mode_left   = 0;
  int unsigned     rx_tick     = 0;

  priority_aging_process_scheduler DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // result side: a long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= STALL_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((rx_tick % 3) != 0);
      endcase
    end
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [PID_W-1:0] tpid,
                           input logic [PRIO_IN_W-1:0] newp);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, newp, tpid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, tpid, newp);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // let every outstanding transaction come back, then allow the block to settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_child_priority(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.child_prio = value;
    cfg_valid_i <= 1'b0;
  endtask

  // slot 0 can never be forked again, so losing it is held back until the last phase
  task automatic pick_item(input bit allow_loss, output sched_item_t it);
    int unsigned r, bad;
    r   = $urandom_range(0, 99);
    bad = $urandom_range(0, 7);
    it.tpid = ($urandom_range(0, 9) == 0) ? ((bad == 0) ? 4'd0 : PID_W'(8 + bad))
                                          : PID_W'($urandom_range(1, NUM_SLOTS));
    case ($urandom_range(0, 4))
      0:       it.newp = '0;
      1:       it.newp = '1;
      default: it.newp = $urandom;
    endcase
    if (r < 34)      it.op = OP_SCHED;
    else if (r < 48) it.op = OP_FORK;
    else if (r < 56) it.op = OP_EXIT;
    else if (r < 64) it.op = OP_EXEC;
    else if (r < 76) it.op = OP_KILL;
    else if (r < 96) it.op = OP_NICE;
    else             it.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    if (!allow_loss && ((it.op == OP_EXIT && sb.cur_slot == 0) ||
                        (it.op == OP_KILL && it.tpid == 1)))
      it.op = OP_SCHED;
  endtask

  task automatic random_phase(input int unsigned count, input bit allow_loss);
    int unsigned sent, burst;
    sched_item_t it;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < count) begin
        pick_item(allow_loss, it);
        send_item(it.op, it.tpid, it.newp);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic flood_under_hold(input int unsigned count);
    sched_item_t it;
    hold_seq <= hold_seq + 1;
    repeat (count) begin
      pick_item(1'b0, it);
      send_item(it.op, it.tpid, it.newp);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing else alive: slot 0 is re-dispatched
    send_item(OP_SCHED, 4'd1, 8'd0);
    send_item(OP_EXEC, 4'd1, 8'd0);
    send_item(OP_SPARE_LO, 4'd15, 8'hff);
    send_item(OP_SPARE_HI, 4'd0, 8'h00);
    repeat (NUM_SLOTS - 1) send_item(OP_FORK, 4'd1, 8'd0);
    // table full
    send_item(OP_FORK, 4'd1, 8'd0);
    send_item(OP_NICE, 4'd8, 8'hff);
    send_item(OP_NICE, 4'd3, 8'h00);
    send_item(OP_NICE, 4'd0, 8'h55);
    send_item(OP_KILL, 4'd9, 8'h00);
    send_item(OP_NICE, 4'd15, 8'hff);
    send_item(OP_SCHED, 4'd1, 8'd0);
    // running slot killed stays running until the next dispatch
    send_item(OP_KILL, 4'd8, 8'd0);
    send_item(OP_EXEC, 4'd1, 8'd0);
    send_item(OP_SCHED, 4'd1, 8'd0);
    send_item(OP_EXIT, 4'd1, 8'd0);
    send_item(OP_SCHED, 4'd1, 8'd0);

    drain();
    write_child_priority(8'd0);
    flood_under_hold(20);
    random_phase(130, 1'b0);

    drain();
    write_child_priority(8'd255);
    random_phase(140, 1'b0);

    drain();
    write_child_priority(8'd1);
    random_phase(140, 1'b0);

    drain();
    write_child_priority(CFG_W'($urandom_range(2, 254)));
    random_phase(140, 1'b0);

    drain();
    write_child_priority(CFG_W'($urandom_range(0, 255)));
    random_phase(140, 1'b0);

    drain();
    write_child_priority(8'd200);
    random_phase(120, 1'b1);
    // slot 0 gone: fork finds it first and fails
    send_item(OP_KILL, 4'd1, 8'd0);
    send_item(OP_FORK, 4'd1, 8'd0);
    send_item(OP_SCHED, 4'd1, 8'd0);
    send_item(OP_EXIT, 4'd1, 8'd0);
    send_item(OP_SCHED, 4'd1, 8'd0);

    drain();
    if (sb.outcome_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.outcome_q.size()));
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
